FILE: rtl/core/otbd_pkg.sv
// Shared types and constants for the octal text to byte decoder.
// Used by otbd_group_decode and octal_text_to_byte_decoder; no dependencies.
`timescale 1ns / 1ps

package otbd_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  localparam int unsigned GROUP_BYTES = 3;
  localparam int unsigned GROUP_WIDTH = 8 * GROUP_BYTES;

  localparam logic [2:0] LAST_DIGIT_POS = 3'd7;
  localparam logic [2:0] FLUSH_ONE_BYTE = 3'd3;
  localparam logic [2:0] FLUSH_TWO_BYTE = 3'd6;

  typedef struct packed {
    logic [GROUP_WIDTH-1:0] group_bits;
    logic [2:0]             digit_count;
    logic                   stopped;
  } dec_state_t;

  // bytes[0] leaves first
  typedef struct packed {
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [1:0]                  count;
    logic                        has_byte;
    logic                        stream_end;
  } bundle_t;

endpackage

FILE: rtl/core/otbd_group_decode.sv
// Next-state and result-bundle logic for one character beat.
// Depends on otbd_pkg.
`timescale 1ns / 1ps

module otbd_group_decode (
  input  logic [7:0]         in_char,
  input  logic               end_of_message,
  input  otbd_pkg::dec_state_t state_cur,
  output otbd_pkg::dec_state_t state_next,
  output otbd_pkg::bundle_t  bundle
);

  logic                                is_digit;
  logic                                ends;
  logic                                flush_en;
  logic [otbd_pkg::GROUP_WIDTH-1:0]    gb_shift;
  logic [2:0]                          cnt_inc;
  logic [otbd_pkg::GROUP_WIDTH-1:0]    fl_gb;
  logic [2:0]                          fl_cnt;

  assign is_digit = in_char inside {[otbd_pkg::CHAR_ZERO:otbd_pkg::CHAR_SEVEN]};
  assign gb_shift = {state_cur.group_bits[otbd_pkg::GROUP_WIDTH-4:0], in_char[2:0]};
  assign cnt_inc  = state_cur.digit_count + 3'd1;
  assign fl_gb    = is_digit ? gb_shift : state_cur.group_bits;
  assign fl_cnt   = is_digit ? cnt_inc : state_cur.digit_count;

  always_comb begin
    state_next = state_cur;
    bundle     = '0;
    ends       = 1'b0;
    flush_en   = 1'b0;
    if (state_cur.stopped) begin
      if (end_of_message) begin
        state_next = '0;
      end
    end else if (is_digit) begin
      state_next.group_bits  = gb_shift;
      state_next.digit_count = cnt_inc;
      if (state_cur.digit_count == otbd_pkg::LAST_DIGIT_POS) begin
        bundle.bytes[0]       = gb_shift[23:16];
        bundle.bytes[1]       = gb_shift[15:8];
        bundle.bytes[2]       = gb_shift[7:0];
        bundle.count          = 2'd3;
        bundle.has_byte       = 1'b1;
        state_next.group_bits = '0;
      end else begin
        flush_en = end_of_message;
      end
      ends = end_of_message;
    end else begin
      flush_en = 1'b1;
      ends     = 1'b1;
    end

    if (flush_en) begin
      case (fl_cnt)
        otbd_pkg::FLUSH_ONE_BYTE: begin
          bundle.bytes[0] = fl_gb[8:1];
          bundle.count    = 2'd1;
          bundle.has_byte = 1'b1;
        end
        otbd_pkg::FLUSH_TWO_BYTE: begin
          bundle.bytes[0] = fl_gb[17:10];
          bundle.bytes[1] = fl_gb[9:2];
          bundle.count    = 2'd2;
          bundle.has_byte = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (ends) begin
      if (bundle.count == 2'd0) begin
        bundle.count    = 2'd1;
        bundle.has_byte = 1'b0;
      end
      bundle.stream_end  = 1'b1;
      state_next         = '0;
      state_next.stopped = !is_digit && !end_of_message;
    end
  end

endmodule

FILE: rtl/core/octal_text_to_byte_decoder.sv
// Top level of the octal text to byte decoder: input register, decode, result serializer.
// Depends on otbd_pkg and otbd_group_decode.
`timescale 1ns / 1ps

// Usage:
//   Input channel: in_valid/in_ready carry one ASCII character (in_char) and an
//   end_of_message flag per beat. Output channel: out_valid/out_ready carry one
//   result per beat: out_byte, has_byte, run_last (last result of its input beat)
//   and stream_end (last result of the message).
//   Every eighth octal digit yields three bytes; a terminating beat flushes the
//   open group (1 or 2 bytes) or yields one empty result with stream_end.
//   A beat that yields results passes the input register, then loads the result
//   register, which raises out_valid for its first result. Throughput: one input
//   beat per cycle while each beat yields at most one result and out_ready is high;
//   a beat yielding three results holds the input until the single result register
//   drains them in order. Beats that yield no result leave the input register without waiting for it.
//   Reset (rst, synchronous) empties both registers and clears the digit group.
//   When out_ready is low the result register holds; the input register keeps
//   taking beats until it holds one that yields results and then deasserts in_ready.

module octal_text_to_byte_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       stream_end
);

  logic                 s1_valid;
  logic [7:0]           s1_char;
  logic                 s1_eom;
  otbd_pkg::dec_state_t state;
  otbd_pkg::dec_state_t state_next;
  otbd_pkg::bundle_t    bundle_next;
  otbd_pkg::bundle_t    bundle;
  logic                 b_valid;
  logic [1:0]           idx;
  logic                 b_last;
  logic                 b_free;
  logic                 s1_advance;
  logic                 b_load;

  otbd_group_decode u_decode (
    .in_char        (s1_char),
    .end_of_message (s1_eom),
    .state_cur      (state),
    .state_next     (state_next),
    .bundle         (bundle_next)
  );

  assign b_last     = (idx == bundle.count - 2'd1);
  assign b_free     = !b_valid || (out_ready && b_last);
  assign s1_advance = s1_valid && ((bundle_next.count == 2'd0) || b_free);
  assign b_load     = s1_advance && (bundle_next.count != 2'd0);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_char <= in_char;
      s1_eom  <= end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      idx     <= 2'd0;
    end else if (b_load) begin
      b_valid <= 1'b1;
      idx     <= 2'd0;
    end else if (b_valid && out_ready) begin
      if (b_last) begin
        b_valid <= 1'b0;
        idx     <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
    if (b_load) begin
      bundle <= bundle_next;
    end
  end

  assign out_valid  = b_valid;
  assign out_byte   = bundle.bytes[idx];
  assign has_byte   = bundle.has_byte;
  assign run_last   = b_last;
  assign stream_end = bundle.stream_end && b_last;

endmodule
